// ===== rtl/prf_pkg.sv =====
// Shared types, field widths and codes of the packet ring FIFO.
package prf_pkg;

   // Field widths of the request, response and register channels.
   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 7;
   localparam int STATUS_W   = 2;
   localparam int SLOTS_W    = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd3;

   // Request type codes.
   localparam logic REQ_SEND = 1'b0;
   localparam logic REQ_RECV = 1'b1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_SLOTS_IN_USE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SLOT_BYTES   = 1'd1;

   // Command from the front end to the response sequencer.
   typedef struct packed {
      logic                stream;
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0]    len;
   } prf_cmd_type;

endpackage

// ===== rtl/prf_ifs.sv =====
// Channel interfaces of the packet ring FIFO: request, response and register write.
interface prf_req_if
   import prf_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic             req_type;
   logic [BYTE_W-1:0] data_byte;
   logic             byte_present;
   logic             last_byte;
   logic [LEN_W-1:0] recv_limit;

   modport source (output valid, req_type, data_byte, byte_present, last_byte, recv_limit,
                   input ready);
   modport sink   (input valid, req_type, data_byte, byte_present, last_byte, recv_limit,
                   output ready);
endinterface

interface prf_rsp_if
   import prf_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   out_byte;
   logic                out_byte_valid;
   logic                out_last;
   logic [LEN_W-1:0]    packet_length;

   modport source (output valid, status, out_byte, out_byte_valid, out_last, packet_length,
                   input ready);
   modport sink   (input valid, status, out_byte, out_byte_valid, out_last, packet_length,
                   output ready);
endinterface

interface prf_csr_if
   import prf_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/prf_front.sv =====
// Front end: registers, ring bookkeeping, send byte writes and request classification.
module prf_front
   import prf_pkg::*;
#(
   parameter int RING_SLOTS_MAX = 16,
   parameter int SLOT_BYTES_MAX = 64,
   localparam int SW    = (RING_SLOTS_MAX > 1) ? $clog2(RING_SLOTS_MAX) : 1,
   localparam int DEPTH = RING_SLOTS_MAX * SLOT_BYTES_MAX,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   prf_req_if.sink              req,
   prf_csr_if.sink              csr,
   output logic                 cmd_valid,
   output prf_cmd_type          cmd_data,
   output logic [SW-1:0]        cmd_slot,
   input  logic                 cmd_ready,
   input  logic                 stream_done,
   output logic                 wr_en,
   output logic [AW-1:0]        wr_addr,
   output logic [BYTE_W-1:0]    wr_data
);

   localparam int CW    = $clog2(RING_SLOTS_MAX + 1);
   localparam int BW    = (SLOT_BYTES_MAX > 1) ? $clog2(SLOT_BYTES_MAX) : 1;

   // Configuration registers.
   logic [SLOTS_W-1:0] slots_ff, slots_in;
   logic [LEN_W-1:0]   bytes_ff, bytes_in;

   // Ring bookkeeping and the send in progress.
   logic [SW-1:0]    read_slot_ff, read_slot_in;
   logic [SW-1:0]    write_slot_ff, write_slot_in;
   logic [CW-1:0]    queued_ff, queued_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic             ovr_ff, ovr_in;
   logic             blk_ff, blk_in;
   logic [1:0]       streams_ff, streams_in;

   // Slot length store with a registered head read.
   logic [LEN_W-1:0] len_mem [RING_SLOTS_MAX];
   logic [LEN_W-1:0] head_len_ff;
   logic             len_we;
   logic [LEN_W-1:0] commit_len;

   logic [CW-1:0]    ns;
   logic [LEN_W-1:0] nb;
   logic             usable;
   logic             is_send;
   logic             accept;
   logic             push_stream;

   function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s, input logic [CW-1:0] n);
      logic [CW-1:0] inc;
      inc = CW'(s) + CW'(1);
      if (inc >= n) begin
         next_slot = '0;
      end else begin
         next_slot = SW'(inc);
      end
   endfunction

   // Effective ring size and slot size, saturated at the build limits.
   always_comb begin
      if (32'(slots_ff) > RING_SLOTS_MAX) begin
         ns = CW'(RING_SLOTS_MAX);
      end else begin
         ns = CW'(slots_ff);
      end
      if (32'(bytes_ff) > SLOT_BYTES_MAX) begin
         nb = LEN_W'(SLOT_BYTES_MAX);
      end else begin
         nb = bytes_ff;
      end
      usable = (ns != '0) && (nb != '0);
   end

   // Sends are held off while a receive still streams out of the payload store,
   // and no request is taken in the cycle of a register write.
   assign is_send   = (req.req_type == REQ_SEND);
   assign req.ready = cmd_ready && !csr.valid && !(is_send && (streams_ff != 2'd0));
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;

   // Request classification and next state of the ring.
   always_comb begin
      slots_in      = slots_ff;
      bytes_in      = bytes_ff;
      read_slot_in  = read_slot_ff;
      write_slot_in = write_slot_ff;
      queued_in     = queued_ff;
      cnt_in        = cnt_ff;
      ovr_in        = ovr_ff;
      blk_in        = blk_ff;
      len_we        = 1'b0;
      commit_len    = cnt_ff;
      wr_en         = 1'b0;
      cmd_valid     = 1'b0;
      cmd_data      = '0;
      cmd_slot      = read_slot_ff;
      push_stream   = 1'b0;

      if (csr.valid) begin
         if (csr.index == REG_SLOTS_IN_USE) begin
            slots_in = csr.data[SLOTS_W-1:0];
         end else begin
            bytes_in = csr.data;
         end
         read_slot_in  = '0;
         write_slot_in = '0;
         queued_in     = '0;
         cnt_in        = '0;
         ovr_in        = 1'b0;
         blk_in        = 1'b0;
      end else if (accept && is_send) begin
         // Store a present byte, or note why it cannot be stored.
         if (req.byte_present) begin
            if (cnt_ff >= nb) begin
               ovr_in = 1'b1;
            end else begin
               if (usable && (queued_ff < ns)) begin
                  wr_en = 1'b1;
               end else begin
                  blk_in = 1'b1;
               end
               cnt_in = cnt_ff + LEN_W'(1);
            end
         end
         // The last item commits the packet or reports why it cannot.
         if (req.last_byte) begin
            cmd_valid       = 1'b1;
            cmd_data.stream = 1'b0;
            if (!usable || ovr_in) begin
               cmd_data.status = STATUS_INVALID;
            end else if ((queued_ff >= ns) || blk_in) begin
               cmd_data.status = STATUS_FULL;
            end else begin
               cmd_data.status = STATUS_OK;
               cmd_data.len    = cnt_in;
               commit_len      = cnt_in;
               len_we          = 1'b1;
               write_slot_in   = next_slot(write_slot_ff, ns);
               queued_in       = queued_ff + CW'(1);
            end
            cnt_in = '0;
            ovr_in = 1'b0;
            blk_in = 1'b0;
         end
      end else if (accept) begin
         // Receive: report an error or pop the oldest packet.
         cmd_valid       = 1'b1;
         cmd_data.stream = 1'b0;
         if (!usable) begin
            cmd_data.status = STATUS_INVALID;
         end else if (queued_ff == '0) begin
            cmd_data.status = STATUS_EMPTY;
         end else if (head_len_ff > req.recv_limit) begin
            cmd_data.status = STATUS_INVALID;
         end else begin
            cmd_data.status = STATUS_OK;
            cmd_data.len    = head_len_ff;
            cmd_data.stream = (head_len_ff != '0);
            push_stream     = (head_len_ff != '0);
            read_slot_in    = next_slot(read_slot_ff, ns);
            queued_in       = queued_ff - CW'(1);
         end
      end
   end

   // Count of receive streams still holding a slot of the payload store.
   always_comb begin
      streams_in = streams_ff;
      if (push_stream && !stream_done) begin
         streams_in = streams_ff + 2'd1;
      end else if (!push_stream && stream_done) begin
         streams_in = streams_ff - 2'd1;
      end
   end

   assign wr_addr = AW'(write_slot_ff) * AW'(SLOT_BYTES_MAX) + AW'(cnt_ff[BW-1:0]);
   assign wr_data = req.data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff      <= SLOTS_W'(16);
         bytes_ff      <= LEN_W'(64);
         read_slot_ff  <= '0;
         write_slot_ff <= '0;
         queued_ff     <= '0;
         cnt_ff        <= '0;
         ovr_ff        <= 1'b0;
         blk_ff        <= 1'b0;
         streams_ff    <= 2'd0;
      end else begin
         slots_ff      <= slots_in;
         bytes_ff      <= bytes_in;
         read_slot_ff  <= read_slot_in;
         write_slot_ff <= write_slot_in;
         queued_ff     <= queued_in;
         cnt_ff        <= cnt_in;
         ovr_ff        <= ovr_in;
         blk_ff        <= blk_in;
         streams_ff    <= streams_in;
      end
   end

   // Length store: written at commit, head entry read into a register with bypass.
   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[write_slot_ff] <= commit_len;
      end
      if (len_we && (write_slot_ff == read_slot_in)) begin
         head_len_ff <= commit_len;
      end else begin
         head_len_ff <= len_mem[read_slot_in];
      end
   end

endmodule

// ===== rtl/prf_cmd_fifo.sv =====
// Two-entry command queue between the front end and the response sequencer.
module prf_cmd_fifo #(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wptr_ff, wptr_in;
   logic             rptr_ff, rptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and occupancy update.
   always_comb begin
      wptr_in  = push ? !wptr_ff : wptr_ff;
      rptr_in  = pop ? !rptr_ff : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= in_data;
      end
   end

endmodule

// ===== rtl/prf_back.sv =====
// Response sequencer: payload store, byte streaming and the response output register.
module prf_back
   import prf_pkg::*;
#(
   parameter int RING_SLOTS_MAX = 16,
   parameter int SLOT_BYTES_MAX = 64,
   localparam int SW    = (RING_SLOTS_MAX > 1) ? $clog2(RING_SLOTS_MAX) : 1,
   localparam int DEPTH = RING_SLOTS_MAX * SLOT_BYTES_MAX,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  prf_cmd_type       cmd_data,
   input  logic [SW-1:0]     cmd_slot,
   output logic              cmd_ready,
   output logic              stream_done,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   prf_rsp_if.source         rsp
);

   localparam int BW    = (SLOT_BYTES_MAX > 1) ? $clog2(SLOT_BYTES_MAX) : 1;

   // Payload store.
   logic [BYTE_W-1:0] payload_mem [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;
   logic [AW-1:0]     rd_addr;

   // Stream sequencer.
   logic             act_ff, act_in;
   logic [SW-1:0]    slot_ff, slot_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             hold_ff, hold_in;
   logic             hold_last_ff;

   // Response output register.
   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] out_status_ff;
   logic [BYTE_W-1:0]   out_byte_ff;
   logic                out_bvalid_ff;
   logic                out_last_ff;
   logic [LEN_W-1:0]    out_len_ff;

   logic out_free;
   logic move;
   logic issue;
   logic last_issue;
   logic pop;
   logic load_single;

   assign out_free    = !out_valid_ff || rsp.ready;
   assign move        = hold_ff && out_free;
   assign issue       = act_ff && (!hold_ff || move);
   assign last_issue  = issue && ((idx_ff + LEN_W'(1)) == len_ff);
   assign cmd_ready   = !act_ff && !hold_ff && (cmd_data.stream || out_free);
   assign pop         = cmd_valid && cmd_ready;
   assign load_single = pop && !cmd_data.stream;
   assign stream_done = last_issue;
   assign rd_addr     = AW'(slot_ff) * AW'(SLOT_BYTES_MAX) + AW'(idx_ff[BW-1:0]);

   // Sequencer next state: start a stream on a command, one read per free output slot.
   always_comb begin
      act_in  = act_ff;
      slot_in = slot_ff;
      idx_in  = idx_ff;
      len_in  = len_ff;
      if (pop && cmd_data.stream) begin
         act_in  = 1'b1;
         slot_in = cmd_slot;
         idx_in  = '0;
         len_in  = cmd_data.len;
      end else if (issue) begin
         idx_in = idx_ff + LEN_W'(1);
         if (last_issue) begin
            act_in = 1'b0;
         end
      end
      if (issue) begin
         hold_in = 1'b1;
      end else if (move) begin
         hold_in = 1'b0;
      end else begin
         hold_in = hold_ff;
      end
      if (move || load_single) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         hold_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         act_ff       <= act_in;
         hold_ff      <= hold_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      idx_ff  <= idx_in;
      len_ff  <= len_in;
      if (issue) begin
         hold_last_ff <= last_issue;
      end
   end

   // Payload store: one write port from the front end, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         payload_mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         rdata_ff <= payload_mem[rd_addr];
      end
   end

   // Output register takes a streamed byte or a single status response.
   always_ff @(posedge clock) begin
      if (move) begin
         out_status_ff <= STATUS_OK;
         out_byte_ff   <= rdata_ff;
         out_bvalid_ff <= 1'b1;
         out_last_ff   <= hold_last_ff;
         out_len_ff    <= len_ff;
      end else if (load_single) begin
         out_status_ff <= cmd_data.status;
         out_byte_ff   <= '0;
         out_bvalid_ff <= 1'b0;
         out_last_ff   <= 1'b1;
         out_len_ff    <= cmd_data.len;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.status         = out_status_ff;
   assign rsp.out_byte       = out_byte_ff;
   assign rsp.out_byte_valid = out_bvalid_ff;
   assign rsp.out_last       = out_last_ff;
   assign rsp.packet_length  = out_len_ff;

endmodule

// ===== rtl/packet_ring_fifo_core.sv =====
// Top level of the packet ring FIFO: front end, command queue and response sequencer.
//
//   Channel    Direction  Handshake            Moves
//   req_chan   in         valid / ready        one request: a send item or a receive
//   rsp_chan   out        valid / ready        one response: status, byte, last, length
//   csr_chan   in         valid / ready (=1)   register write: index, data
//
// Send items may follow back to back; a commit passes through the command queue.
// A successful receive of n > 0 bytes streams n responses at one byte per cycle while
// rsp_chan is ready; the first passes through the command queue and the store read.
// Send items stall while a receive still streams from the single-read payload store.
// Reset is synchronous and needs no clearing pass; a register write clears the ring.
// Either side may stall; the command queue lets the front end run ahead by two commands.
module packet_ring_fifo_core
   import prf_pkg::*;
#(
   parameter int RING_SLOTS_MAX = 16,
   parameter int SLOT_BYTES_MAX = 64
) (
   input logic       clock,
   input logic       reset,
   prf_req_if.sink   req_chan,
   prf_rsp_if.source rsp_chan,
   prf_csr_if.sink   csr_chan
);

   localparam int SW    = (RING_SLOTS_MAX > 1) ? $clog2(RING_SLOTS_MAX) : 1;
   localparam int DEPTH = RING_SLOTS_MAX * SLOT_BYTES_MAX;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int QW    = $bits(prf_cmd_type) + SW;

   logic              f_cmd_valid;
   prf_cmd_type       f_cmd_data;
   logic [SW-1:0]     f_cmd_slot;
   logic              f_cmd_ready;
   logic              b_cmd_valid;
   prf_cmd_type       b_cmd_data;
   logic [SW-1:0]     b_cmd_slot;
   logic              b_cmd_ready;
   logic              stream_done;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [BYTE_W-1:0] wr_data;

   // Front end.
   prf_front #(
      .RING_SLOTS_MAX (RING_SLOTS_MAX),
      .SLOT_BYTES_MAX (SLOT_BYTES_MAX)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .csr         (csr_chan),
      .cmd_valid   (f_cmd_valid),
      .cmd_data    (f_cmd_data),
      .cmd_slot    (f_cmd_slot),
      .cmd_ready   (f_cmd_ready),
      .stream_done (stream_done),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data)
   );

   // Command queue.
   prf_cmd_fifo #(
      .WIDTH (QW)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_cmd_valid),
      .in_ready  (f_cmd_ready),
      .in_data   ({f_cmd_data, f_cmd_slot}),
      .out_valid (b_cmd_valid),
      .out_ready (b_cmd_ready),
      .out_data  ({b_cmd_data, b_cmd_slot})
   );

   // Response sequencer.
   prf_back #(
      .RING_SLOTS_MAX (RING_SLOTS_MAX),
      .SLOT_BYTES_MAX (SLOT_BYTES_MAX)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (b_cmd_valid),
      .cmd_data    (b_cmd_data),
      .cmd_slot    (b_cmd_slot),
      .cmd_ready   (b_cmd_ready),
      .stream_done (stream_done),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rsp         (rsp_chan)
   );

   // A payload byte only appears in a successful receive with a nonzero length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.out_byte_valid |->
         (rsp_chan.status == STATUS_OK) && (rsp_chan.packet_length != '0))
      else $error("payload byte outside a successful receive");

   // A response without a payload byte always ends its request and carries a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.out_byte_valid |->
         rsp_chan.out_last && (rsp_chan.out_byte == '0))
      else $error("status response not marked last");

   // The payload store is never written in a cycle where a stream starts.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !(b_cmd_valid && b_cmd_ready && b_cmd_data.stream))
      else $error("payload write while a stream starts");

   // The queue never receives a command it cannot hold.
   assert property (@(posedge clock) disable iff (reset)
      f_cmd_valid |-> f_cmd_ready)
      else $error("command pushed into a full queue");

endmodule
